### sv/rtmp_pkg.sv
// ---------------------------------------------------------------------------
// rtmp_pkg
// shared constants and types for the chunk stream deframer
// ---------------------------------------------------------------------------
package rtmp_pkg;
  localparam int CHANNELS = 64;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [23:0] CHUNK_SIZE_RST = 24'd128;
  localparam logic [23:0] TS_EXT_MARK = 24'hffffff;

  // configuration register addresses
  localparam logic [1:0] REG_CHUNK_SIZE = 2'd0;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  typedef enum logic [5:0] {
    PH_BASIC   = 6'b000001,
    PH_CID_LO  = 6'b000010,
    PH_CID_HI  = 6'b000100,
    PH_MSGHDR  = 6'b001000,
    PH_EXTTS   = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  // one channel table entry
  typedef struct packed {
    logic [31:0] ts_delta;
    logic [23:0] length;
    logic [7:0]  mtype;
    logic [31:0] stream_id;
    logic [23:0] bytes_left;
    logic [31:0] timestamp;
    logic        busy;
  } chan_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [16:0] channel;
    logic [7:0]  message_type;
    logic [31:0] stream_id;
    logic [31:0] timestamp;
    logic        message_end;
  } result_t;
endpackage

### sv/rtmp_if.sv
// ---------------------------------------------------------------------------
// rtmp_in_if / rtmp_out_if
// valid/ready channels for input bytes and result words
// ---------------------------------------------------------------------------
interface rtmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rtmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [16:0] channel;
  logic [7:0]  message_type;
  logic [31:0] stream_id;
  logic [31:0] timestamp;
  logic        message_end;
  modport source (output valid, output kind, output payload_byte, output channel,
                  output message_type, output stream_id, output timestamp,
                  output message_end, input ready);
  modport sink (input valid, input kind, input payload_byte, input channel,
                input message_type, input stream_id, input timestamp,
                input message_end, output ready);
endinterface

### sv/rtmp_chunk_deframer_top.sv
// ---------------------------------------------------------------------------
// rtmp_chunk_deframer_top
// chunk stream deframer with a per-channel table in block ram
// ---------------------------------------------------------------------------
// Bytes of the chunk stream enter on in_ (valid/ready), one word per cycle.
// Each payload byte leaves on out_ tagged with channel, type, stream id,
// timestamp and an end-of-message flag; empty messages and an out-of-range
// channel give one word each. A byte is taken every cycle while the output
// register is free or being drained. The result word is built in order:
// accepting a byte registers it and reads the table entry of the channel
// that byte works on, and the modify stage then writes the modified entry
// back and loads the output register.
// The table is a one-port-write, one-port-read memory with a registered
// read; the read address is looked ahead from the incoming byte and the
// parse state, and the modify stage forwards its own write when the next
// byte reads the same entry.
// After reset a clearing pass writes a zero entry for every channel while
// no byte is taken; chunk_size is still writable then (reset value 128).
// When out_ready is low on a valid word, it stays in the output register
// and input is stalled. An out-of-range channel halts the block until reset.
// ---------------------------------------------------------------------------
module rtmp_chunk_deframer_top
  import rtmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rtmp_in_if.sink     in_ch,
  rtmp_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // config register
  logic [23:0] chunk_size_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CHUNK_SIZE) ? {8'd0, chunk_size_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= CHUNK_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_CHUNK_SIZE) begin
      chunk_size_r <= cfg_pwdata[23:0];
    end
  end

  // clearing pass
  logic          clr_r;
  logic [CH_W:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == (CH_W+1)'(CHANNELS - 1)) clr_r <= 1'b0;
    end
  end

  // channel table
  chan_t mem [CHANNELS];
  chan_t rd_q;
  logic  wr_en;
  logic [CH_W-1:0] wr_addr, rd_addr;
  chan_t wr_data;

  // stage 1: byte register plus table read
  logic        s1_v_r;
  logic [7:0]  s1_b_r;
  logic [16:0] s1_ch_r;
  logic [16:0] la_ch;
  logic        out_v_r;
  logic        stall;
  logic        halted_r;
  logic [16:0] cur_ch_r;

  assign stall = out_v_r && !out_ch.ready;
  assign in_ch.ready = !clr_r && !stall;
  wire in_acc = in_ch.valid && in_ch.ready;
  assign rd_addr = la_ch[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (!stall) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!stall) begin
      s1_v_r <= in_acc;
    end
  end
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_b_r  <= in_ch.data_byte;
      s1_ch_r <= la_ch;
    end
  end

  // stage 2: parse and modify
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [16:0] cur_ch_nxt;
  logic [23:0] cbl_r, cbl_nxt;
  logic        two_r, two_nxt;
  logic        halted_nxt;
  chan_t       fwd_r;
  logic        fwd_v_r;
  chan_t       e, e_nxt;
  result_t     res, out_r;
  logic        res_v;
  logic        known, fin, ahdr;
  logic [16:0] ch_new;
  logic [23:0] cs, bl_dec;
  logic [3:0]  hlen;
  logic [3:0]  k1;

  assign e = fwd_v_r ? fwd_r : rd_q;
  assign cs = (chunk_size_r == 24'd0) ? 24'd1 : chunk_size_r;

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    fmt_nxt    = fmt_r;
    cur_ch_nxt = cur_ch_r;
    cbl_nxt    = cbl_r;
    two_nxt    = two_r;
    halted_nxt = halted_r;
    e_nxt      = e;
    res        = '0;
    res_v      = 1'b0;
    known      = 1'b0;
    ahdr       = 1'b0;
    fin        = 1'b0;
    ch_new     = cur_ch_r;
    bl_dec     = 24'd0;
    k1         = hcnt_r + 4'd1;
    case (fmt_r)
      2'd0: hlen = 4'd11;
      2'd1: hlen = 4'd7;
      2'd2: hlen = 4'd3;
      default: hlen = 4'd0;
    endcase
    if (s1_v_r && !halted_r) begin
      unique case (phase_r)
        PH_BASIC: begin
          fmt_nxt = s1_b_r[7:6];
          if (s1_b_r[5:1] == 5'd0) begin
            two_nxt   = s1_b_r[0];
            phase_nxt = PH_CID_LO;
          end else begin
            ch_new = {11'd0, s1_b_r[5:0]};
            known  = 1'b1;
          end
        end
        PH_CID_LO: begin
          if (two_r) begin
            cur_ch_nxt = {9'd0, s1_b_r};
            phase_nxt  = PH_CID_HI;
          end else begin
            ch_new = {9'd0, s1_b_r} + 17'd64;
            known  = 1'b1;
          end
        end
        PH_CID_HI: begin
          ch_new = {9'd0, cur_ch_r[7:0]} + {1'b0, s1_b_r, 8'd0} + 17'd64;
          known  = 1'b1;
        end
        PH_MSGHDR: begin
          if (hcnt_r < 4'd3)
            e_nxt.ts_delta = (hcnt_r == 4'd0) ? {24'd0, s1_b_r}
                           : {8'd0, e.ts_delta[15:0], s1_b_r};
          else if (hcnt_r < 4'd6)
            e_nxt.length = (hcnt_r == 4'd3) ? {16'd0, s1_b_r}
                         : {e.length[15:0], s1_b_r};
          else if (hcnt_r == 4'd6)
            e_nxt.mtype = s1_b_r;
          else if (hcnt_r < 4'd11)
            case (hcnt_r)
              4'd7: e_nxt.stream_id = {24'd0, s1_b_r};
              4'd8: e_nxt.stream_id[15:8] = s1_b_r;
              4'd9: e_nxt.stream_id[23:16] = s1_b_r;
              default: e_nxt.stream_id[31:24] = s1_b_r;
            endcase
          hcnt_nxt = k1;
          if (k1 >= hlen) ahdr = 1'b1;
        end
        PH_EXTTS: begin
          e_nxt.ts_delta = (hcnt_r == 4'd0) ? {24'd0, s1_b_r}
                         : {e.ts_delta[23:0], s1_b_r};
          hcnt_nxt = k1;
          if (k1 >= 4'd4) fin = 1'b1;
        end
        PH_PAYLOAD: begin
          if (cbl_r != 24'd0) cbl_nxt = cbl_r - 24'd1;
          bl_dec = (e.bytes_left != 24'd0) ? e.bytes_left - 24'd1 : 24'd0;
          e_nxt.bytes_left = bl_dec;
          res_v = 1'b1;
          res.kind = KIND_PAYLOAD;
          res.payload_byte = s1_b_r;
          res.channel = cur_ch_r;
          res.message_type = e.mtype;
          res.stream_id = e.stream_id;
          res.timestamp = e.timestamp;
          if (bl_dec == 24'd0) begin
            e_nxt.busy = 1'b0;
            cbl_nxt = 24'd0;
            res.message_end = 1'b1;
          end
          if (bl_dec == 24'd0 || cbl_nxt == 24'd0) phase_nxt = PH_BASIC;
        end
        default: phase_nxt = PH_BASIC;
      endcase
      // channel resolved: out of range, message header next, or (format 3) header done
      if (known) begin
        cur_ch_nxt = ch_new;
        if (ch_new >= 17'(CHANNELS)) begin
          halted_nxt = 1'b1;
          res_v = 1'b1;
          res.kind = KIND_RANGE;
          res.channel = ch_new;
        end else if (fmt_nxt != 2'd3) begin
          phase_nxt = PH_MSGHDR;
          hcnt_nxt  = 4'd0;
        end else begin
          ahdr = 1'b1;
        end
      end
      if (ahdr) begin
        if (e_nxt.ts_delta == {8'd0, TS_EXT_MARK}) begin
          phase_nxt = PH_EXTTS;
          hcnt_nxt  = 4'd0;
        end else begin
          fin = 1'b1;
        end
      end
      // header complete: start message (or give an empty-message word) or continue it
      if (fin) begin
        if (!e_nxt.busy) begin
          e_nxt.timestamp = (fmt_nxt == 2'd0) ? e_nxt.ts_delta
                          : e_nxt.timestamp + e_nxt.ts_delta;
          e_nxt.bytes_left = e_nxt.length;
          if (e_nxt.length == 24'd0) begin
            phase_nxt = PH_BASIC;
            res_v = 1'b1;
            res.kind = KIND_EMPTY;
            res.channel = cur_ch_nxt;
            res.message_type = e_nxt.mtype;
            res.stream_id = e_nxt.stream_id;
            res.timestamp = e_nxt.timestamp;
            res.message_end = 1'b1;
          end else begin
            e_nxt.busy = 1'b1;
          end
        end
        if (!res_v) begin
          cbl_nxt = (e_nxt.bytes_left < cs) ? e_nxt.bytes_left : cs;
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  // table address for the incoming byte: the channel that byte works on
  always_comb begin
    la_ch = cur_ch_nxt;
    if (phase_nxt == PH_BASIC && in_ch.data_byte[5:1] != 5'd0)
      la_ch = {11'd0, in_ch.data_byte[5:0]};
    else if (phase_nxt == PH_CID_LO && !two_nxt)
      la_ch = {9'd0, in_ch.data_byte} + 17'd64;
    else if (phase_nxt == PH_CID_HI)
      la_ch = {9'd0, cur_ch_nxt[7:0]} + {1'b0, in_ch.data_byte, 8'd0} + 17'd64;
  end

  // table write: clearing pass or modify result
  wire s2_go = s1_v_r && !halted_r && !stall;
  always_comb begin
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[CH_W-1:0];
      wr_data = '0;
    end else begin
      wr_en   = s2_go && (s1_ch_r < 17'(CHANNELS));
      wr_addr = s1_ch_r[CH_W-1:0];
      wr_data = e_nxt;
    end
  end

  // a stalled cycle keeps the forward copy valid since the read is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (!stall) begin
      fwd_v_r <= wr_en && !clr_r && (wr_addr == rd_addr);
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) fwd_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BASIC;
      hcnt_r   <= 4'd0;
      fmt_r    <= 2'd0;
      cur_ch_r <= 17'd0;
      cbl_r    <= 24'd0;
      two_r    <= 1'b0;
      halted_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (!stall) begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      fmt_r    <= fmt_nxt;
      cur_ch_r <= cur_ch_nxt;
      cbl_r    <= cbl_nxt;
      two_r    <= two_nxt;
      halted_r <= halted_nxt;
      out_v_r  <= res_v && s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!stall && res_v) out_r <= res;
  end

  // output word
  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.payload_byte = out_r.payload_byte;
  assign out_ch.channel      = out_r.channel;
  assign out_ch.message_type = out_r.message_type;
  assign out_ch.stream_id    = out_r.stream_id;
  assign out_ch.timestamp    = out_r.timestamp;
  assign out_ch.message_end  = out_r.message_end;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for rtmp_chunk_deframer_top: chunk streams with random
// headers, formats, timestamps and payload go in byte by byte; a bit-exact
// parser model predicts every result word, which is checked field by field
// ---------------------------------------------------------------------------
module tb;
  import rtmp_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_BYTES = 225;

  // parser state, kept once for stimulus shaping and once for checking
  typedef struct {
    logic [23:0] csize;
    phase_t      phase;
    logic [3:0]  hcnt;
    logic [1:0]  fmt;
    logic [16:0] cur;
    logic [23:0] chunk_left;
    bit          halted;
    bit          two_byte_id;
    chan_t       tbl[CHANNELS];
  } deframer_st_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  rtmp_in_if  in_if();
  rtmp_out_if out_if();

  rtmp_chunk_deframer_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  deframer_st_t plan_st;
  deframer_st_t live_st;
  logic [7:0] pending_bytes[$];
  result_t    expected_words[$];
  int  send_idle_pct, recv_stall_pct;
  int  n_fail, n_bytes, cycle_cnt, hold_cnt;
  bit  long_hold;

  // clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // ---------------- parser model ----------------
  function automatic int hdr_len(logic [1:0] f);
    case (f)
      2'd0: return 11;
      2'd1: return 7;
      2'd2: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic void put_word(ref deframer_st_t s, output result_t r,
                                   input logic [1:0] kind, input logic [7:0] b,
                                   input logic [16:0] ch, input logic last);
    r = '0;
    r.kind = kind;
    r.payload_byte = b;
    r.channel = ch;
    if (kind != KIND_RANGE && ch < CHANNELS) begin
      r.message_type = s.tbl[ch].mtype;
      r.stream_id = s.tbl[ch].stream_id;
      r.timestamp = s.tbl[ch].timestamp;
    end
    r.message_end = last;
  endfunction

  function automatic bit finish_header(ref deframer_st_t s, output result_t r);
    logic [16:0] ch;
    logic [23:0] cs;
    ch = s.cur;
    cs = (s.csize == 24'd0) ? 24'd1 : s.csize;
    r = '0;
    if (!s.tbl[ch].busy) begin
      if (s.fmt == 2'd0) s.tbl[ch].timestamp = s.tbl[ch].ts_delta;
      else s.tbl[ch].timestamp = s.tbl[ch].timestamp + s.tbl[ch].ts_delta;
      s.tbl[ch].bytes_left = s.tbl[ch].length;
      if (s.tbl[ch].bytes_left == 24'd0) begin
        s.phase = PH_BASIC;
        put_word(s, r, KIND_EMPTY, 8'd0, ch, 1'b1);
        return 1;
      end
      s.tbl[ch].busy = 1'b1;
    end
    s.chunk_left = (s.tbl[ch].bytes_left < cs) ? s.tbl[ch].bytes_left : cs;
    s.phase = PH_PAYLOAD;
    return 0;
  endfunction

  function automatic bit after_msghdr(ref deframer_st_t s, output result_t r);
    r = '0;
    if (s.tbl[s.cur].ts_delta == {8'd0, TS_EXT_MARK}) begin
      s.phase = PH_EXTTS;
      s.hcnt = 4'd0;
      return 0;
    end
    return finish_header(s, r);
  endfunction

  function automatic bit channel_known(ref deframer_st_t s, output result_t r);
    r = '0;
    if (s.cur >= CHANNELS) begin
      s.halted = 1'b1;
      put_word(s, r, KIND_RANGE, 8'd0, s.cur, 1'b0);
      return 1;
    end
    if (s.fmt < 2'd3) begin
      s.phase = PH_MSGHDR;
      s.hcnt = 4'd0;
      return 0;
    end
    return after_msghdr(s, r);
  endfunction

  // one stream byte in, zero or one result word out
  function automatic bit deframe(ref deframer_st_t s, input logic [7:0] b,
                                 output result_t r);
    logic [16:0] ch;
    int k;
    bit last;
    r = '0;
    ch = s.cur;
    if (s.halted) return 0;
    case (s.phase)
      PH_BASIC: begin
        s.fmt = b[7:6];
        if (b[5:0] < 6'd2) begin
          s.two_byte_id = b[0];
          s.phase = PH_CID_LO;
          return 0;
        end
        s.cur = {11'd0, b[5:0]};
        return channel_known(s, r);
      end
      PH_CID_LO: begin
        if (s.two_byte_id) begin
          s.cur = {9'd0, b};
          s.phase = PH_CID_HI;
          return 0;
        end
        s.cur = {9'd0, b} + 17'd64;
        return channel_known(s, r);
      end
      PH_CID_HI: begin
        s.cur = {9'd0, s.cur[7:0]} + {1'b0, b, 8'd0} + 17'd64;
        return channel_known(s, r);
      end
      PH_MSGHDR: begin
        if (ch >= CHANNELS) begin
          s.halted = 1'b1;
          return 0;
        end
        k = s.hcnt;
        if (k < 3)
          s.tbl[ch].ts_delta = (k == 0) ? {24'd0, b} : {8'd0, s.tbl[ch].ts_delta[15:0], b};
        else if (k < 6)
          s.tbl[ch].length = (k == 3) ? {16'd0, b} : {s.tbl[ch].length[15:0], b};
        else if (k == 6)
          s.tbl[ch].mtype = b;
        else if (k < 11)
          s.tbl[ch].stream_id = (k == 7) ? {24'd0, b} :
                                (s.tbl[ch].stream_id | ({24'd0, b} << (8 * (k - 7))));
        s.hcnt = s.hcnt + 4'd1;
        if (s.hcnt >= hdr_len(s.fmt)) return after_msghdr(s, r);
        return 0;
      end
      PH_EXTTS: begin
        if (ch >= CHANNELS) begin
          s.halted = 1'b1;
          return 0;
        end
        s.tbl[ch].ts_delta = (s.hcnt == 4'd0) ? {24'd0, b} : {s.tbl[ch].ts_delta[23:0], b};
        s.hcnt = s.hcnt + 4'd1;
        if (s.hcnt >= 4'd4) return finish_header(s, r);
        return 0;
      end
      PH_PAYLOAD: begin
        if (ch >= CHANNELS) begin
          s.halted = 1'b1;
          return 0;
        end
        if (s.chunk_left > 24'd0) s.chunk_left--;
        if (s.tbl[ch].bytes_left > 24'd0) s.tbl[ch].bytes_left--;
        last = (s.tbl[ch].bytes_left == 24'd0);
        if (last) begin
          s.tbl[ch].busy = 1'b0;
          s.chunk_left = 24'd0;
        end
        if (s.chunk_left == 24'd0) s.phase = PH_BASIC;
        put_word(s, r, KIND_PAYLOAD, b, ch, last);
        return 1;
      end
      default: begin
        s.phase = PH_BASIC;
        return 0;
      end
    endcase
  endfunction

  function automatic void reset_model(ref deframer_st_t s);
    s.csize = CHUNK_SIZE_RST;
    s.phase = PH_BASIC;
    s.hcnt = 4'd0;
    s.fmt = 2'd0;
    s.cur = 17'd0;
    s.chunk_left = 24'd0;
    s.halted = 1'b0;
    s.two_byte_id = 1'b0;
    for (int i = 0; i < CHANNELS; i++) s.tbl[i] = '0;
  endfunction

  // ---------------- stimulus building ----------------
  task automatic queue_byte(input logic [7:0] b);
    result_t r;
    bit has;
    pending_bytes.push_back(b);
    has = deframe(plan_st, b, r);
    n_bytes++;
  endtask

  // one chunk: basic header, message header, extended timestamp, payload
  task automatic queue_chunk(input logic [16:0] ch, input logic [1:0] fmt,
                             input logic [23:0] ts, input logic [23:0] len,
                             input logic [7:0] mtype, input logic [31:0] sid,
                             input logic [31:0] ext);
    logic [7:0] hb[11];
    logic [16:0] v;
    if (ch < 64) begin
      queue_byte({fmt, ch[5:0]});
    end else if (ch < 320) begin
      v = ch - 17'd64;
      queue_byte({fmt, 6'd0});
      queue_byte(v[7:0]);
    end else begin
      v = ch - 17'd64;
      queue_byte({fmt, 6'd1});
      queue_byte(v[7:0]);
      queue_byte(v[15:8]);
    end
    hb = '{ts[23:16], ts[15:8], ts[7:0], len[23:16], len[15:8], len[7:0], mtype,
           sid[7:0], sid[15:8], sid[23:16], sid[31:24]};
    for (int i = 0; i < hdr_len(fmt) && plan_st.phase == PH_MSGHDR; i++) queue_byte(hb[i]);
    if (plan_st.phase == PH_EXTTS) begin
      queue_byte(ext[31:24]);
      queue_byte(ext[23:16]);
      queue_byte(ext[15:8]);
      queue_byte(ext[7:0]);
    end
    while (plan_st.phase == PH_PAYLOAD) queue_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic complete_message(input logic [16:0] ch);
    while (plan_st.tbl[ch].busy)
      queue_chunk(ch, 2'd3, 24'd0, 24'd0, 8'd0, 32'd0, $urandom);
  endtask

  task automatic queue_random_chunk();
    logic [16:0] ch;
    logic [1:0] fmt;
    logic [23:0] ts, len;
    int roll;
    // a few hot channels, the rest spread; the top channel stays reserved
    ch = ($urandom_range(0, 99) < 70) ? 17'($urandom_range(2, 5))
                                       : 17'($urandom_range(2, 62));
    roll = $urandom_range(0, 99);
    if (plan_st.tbl[ch].busy)
      fmt = (roll < 80) ? 2'd3 : 2'($urandom_range(0, 2));
    else
      fmt = (roll < 55) ? 2'd0 : 2'($urandom_range(1, 3));
    roll = $urandom_range(0, 99);
    ts = (roll < 10) ? TS_EXT_MARK : (roll < 30) ? 24'($urandom_range(0, 40))
                                                 : 24'($urandom);
    roll = $urandom_range(0, 99);
    len = (roll < 8) ? 24'd0 : (roll < 95) ? 24'($urandom_range(1, 40))
                                          : 24'($urandom_range(41, 600));
    roll = $urandom_range(0, 99);
    queue_chunk(ch, fmt, ts, len, 8'($urandom), $urandom,
                (roll < 10) ? {8'd0, TS_EXT_MARK} : (roll < 20) ? 32'hffffffff : $urandom);
  endtask

  // ---------------- configuration port ----------------
  task automatic cfg_write(input logic [1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_CHUNK_SIZE) begin
      plan_st.csize = data[23:0];
      live_st.csize = data[23:0];
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    result_t r;
    bit has;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        has = deframe(live_st, in_if.data_byte, r);
        if (has) expected_words.push_back(r);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data_byte <= pending_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!long_hold) hold_cnt <= 0;
    else if (hold_cnt < LONG_HOLD) hold_cnt <= hold_cnt + 1;
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.kind, out_if.payload_byte, out_if.channel, out_if.message_type,
                out_if.stream_id, out_if.timestamp, out_if.message_end};
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d channel %0d", got.kind, got.channel);
          n_fail++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            n_fail++;
          end
          if (got.payload_byte != want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
            n_fail++;
          end
          if (got.channel != want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, got.channel);
            n_fail++;
          end
          if (got.message_type != want.message_type) begin
            $error("message_type: expected %0h, got %0h", want.message_type,
                   got.message_type);
            n_fail++;
          end
          if (got.stream_id != want.stream_id) begin
            $error("stream_id: expected %0h, got %0h", want.stream_id, got.stream_id);
            n_fail++;
          end
          if (got.timestamp != want.timestamp) begin
            $error("timestamp: expected %0h, got %0h", want.timestamp, got.timestamp);
            n_fail++;
          end
          if (got.message_end != want.message_end) begin
            $error("message_end: expected %0d, got %0d", want.message_end, got.message_end);
            n_fail++;
          end
        end
      end
      out_if.ready <= !(long_hold && hold_cnt < LONG_HOLD) &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[rtmp_chunk_deframer_top] ERROR");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int idle_s[6];
    int idle_r[6];
    logic [23:0] csizes[6];
    int target;
    idle_s = '{0, 0, 83, 0, 12, 0};
    idle_r = '{0, 0, 0, 83, 12, 0};
    csizes = '{24'd128, 24'd1, 24'd7, 24'hffffff, 24'd16, 24'd128};
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'd0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 0;
    hold_cnt = 0;
    n_fail = 0;
    n_bytes = 0;
    cycle_cnt = 0;
    reset_model(plan_st);
    reset_model(live_st);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, extremes, every format, extended timestamps
    cfg_write(REG_CHUNK_SIZE, 32'd128);
    queue_chunk(17'd2, 2'd0, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
    queue_chunk(17'd3, 2'd0, TS_EXT_MARK, 24'd1, 8'hff, 32'hffffffff, 32'hffffffff);
    queue_chunk(17'd3, 2'd1, 24'd16, 24'd2, 8'h55, 32'd0, 32'd0);
    queue_chunk(17'd3, 2'd3, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
    queue_chunk(17'd3, 2'd2, TS_EXT_MARK, 24'd0, 8'd0, 32'd0, {8'd0, TS_EXT_MARK});
    // stored delta is the marker, so a bare continuation header reads it again
    queue_chunk(17'd3, 2'd3, 24'd0, 24'd0, 8'd0, 32'd0, {8'd0, TS_EXT_MARK});
    queue_chunk(17'd3, 2'd3, 24'd0, 24'd0, 8'd0, 32'd0, 32'h80000001);
    // multi-chunk message with another channel interleaved
    queue_chunk(17'd4, 2'd0, 24'h123456, 24'd300, 8'h09, 32'h01020304, 32'd0);
    queue_chunk(17'd5, 2'd0, 24'd7, 24'd3, 8'h08, 32'd1, 32'd0);
    queue_chunk(17'd4, 2'd3, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
    // new header on a busy channel keeps the message in progress
    queue_chunk(17'd4, 2'd0, 24'h000001, 24'd5, 8'h12, 32'd9, 32'd0);
    complete_message(17'd4);
    queue_chunk(17'd6, 2'd1, 24'd3, 24'd0, 8'd4, 32'd0, 32'd0);
    // longest length, left open for good on the top channel
    queue_chunk(17'd63, 2'd0, 24'd0, 24'hffffff, 8'h14, 32'h80000000, 32'd0);
    wait_drained();

    // random phases with different chunk sizes and flow control
    for (int p = 0; p < 6; p++) begin
      if (p > 0) cfg_write(REG_CHUNK_SIZE, {8'd0, csizes[p]});
      send_idle_pct = idle_s[p];
      recv_stall_pct = idle_r[p];
      long_hold = (p == 1);
      target = n_bytes + PHASE_BYTES;
      while (n_bytes < target) begin
        queue_random_chunk();
        // sender holds back until the phase so far has fully drained
        if (p == 4 && n_bytes > target - 150 && n_bytes < target - 100) wait_drained();
      end
      wait_drained();
      long_hold = 0;
    end

    // out-of-range channel by the three-byte form, then the block stays halted
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_byte(8'hc1);
    queue_byte(8'hff);
    queue_byte(8'hff);
    queue_chunk(17'd2, 2'd0, 24'd0, 24'd2, 8'd1, 32'd1, 32'd0);
    wait_drained();

    if (n_fail == 0) begin
      $display("[rtmp_chunk_deframer_top] OK");
    end else begin
      $display("[rtmp_chunk_deframer_top] ERROR");
    end
    $finish;
  end
endmodule
